// ----- hdl/drs_pkg.sv -----
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants for the DAC ramp stepper.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int STEP_BITS = 20;
  localparam int DIR_BITS  = 2;
  localparam int CFG_BITS  = 20;
  localparam int HALF_BITS = 16;
  localparam int FRAME_BITS = 32;
  localparam int FRAME_SHIFT = 4;
  localparam logic [FRAME_BITS-1:0] FRAME_WRITE_CMD = 32'h0100_0000;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_CYCLE = 2'd2
  } dir_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic {
    REG_RAMP_MODE = 1'b0,
    REG_STEP_SIZE = 1'b1
  } reg_index_t;

  typedef struct packed {
    dir_t                 ramp_mode;
    logic [STEP_BITS-1:0] step_size;
  } drs_cfg_t;

endpackage

// ----- hdl/drs_in_if.sv -----
// ----------------------------------------------------------------------------
// drs_in_if
// Item channel into the ramp stepper: valid/ready with operation and load code.
// ----------------------------------------------------------------------------
interface drs_in_if #(
  parameter int CODE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [CODE_BITS-1:0] load_value;

  modport source (output valid, output operation, output load_value, input ready);
  modport sink (input valid, input operation, input load_value, output ready);
endinterface

// ----- hdl/drs_out_if.sv -----
// ----------------------------------------------------------------------------
// drs_out_if
// Result channel of the ramp stepper: valid/ready with the sent frame and code.
// ----------------------------------------------------------------------------
interface drs_out_if #(
  parameter int CODE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 frame_sent;
  logic [15:0]          sent_high_half;
  logic [15:0]          sent_low_half;
  logic [CODE_BITS-1:0] code_now;
  logic                 stop_ramp;

  modport source (
    output valid, output frame_sent, output sent_high_half, output sent_low_half,
    output code_now, output stop_ramp, input ready
  );
  modport sink (
    input valid, input frame_sent, input sent_high_half, input sent_low_half,
    input code_now, input stop_ramp, output ready
  );
endinterface

// ----- hdl/dac_ramp_stepper.sv -----
// ----------------------------------------------------------------------------
// dac_ramp_stepper
// Up/down/triangle DAC ramp stepper with a registered item path.
// ----------------------------------------------------------------------------
// One item per clock sustained while results are taken. An item is captured
// in an input register, then a single pass of add or subtract, limit compare
// and frame build updates the ramp state and loads the result register in
// the same cycle; the ramp code register feeding back into that add is what
// sets the one-item-per-cycle rate. The input side keeps accepting while a
// result waits as long as the input register is empty; once both registers
// hold items it stalls until the result is taken. No clearing pass: the
// block is ready right after reset.
// ----------------------------------------------------------------------------
module dac_ramp_stepper
  import drs_pkg::*;
#(
  parameter int CODE_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  drs_in_if.sink              cmd,
  drs_out_if.source           rsp
);

  drs_cfg_t cfg;

  logic                 s_valid;
  op_t                  s_op;
  logic [CODE_BITS-1:0] s_load;
  logic                 o_valid;
  logic                 advance;

  logic                 c_frame_sent, c_stop;
  logic [HALF_BITS-1:0] c_high, c_low;
  logic [CODE_BITS-1:0] c_code;

  logic                 frame_sent, stop_ramp;
  logic [HALF_BITS-1:0] sent_high_half, sent_low_half;
  logic [CODE_BITS-1:0] code_now;

  drs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  drs_step_core #(.CODE_BITS(CODE_BITS)) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .operation      (s_op),
    .load_value     (s_load),
    .cfg            (cfg),
    .frame_sent     (c_frame_sent),
    .sent_high_half (c_high),
    .sent_low_half  (c_low),
    .code_now       (c_code),
    .stop_ramp      (c_stop)
  );

  assign advance   = s_valid && (!o_valid || rsp.ready);
  assign cmd.ready = !s_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (cmd.ready) begin
      s_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s_op   <= op_t'(cmd.operation);
      s_load <= cmd.load_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_sent     <= c_frame_sent;
      sent_high_half <= c_high;
      sent_low_half  <= c_low;
      code_now       <= c_code;
      stop_ramp      <= c_stop;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.frame_sent     = frame_sent;
  assign rsp.sent_high_half = sent_high_half;
  assign rsp.sent_low_half  = sent_low_half;
  assign rsp.code_now       = code_now;
  assign rsp.stop_ramp      = stop_ramp;

  a_stop_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (o_valid && stop_ramp) |-> frame_sent)
    else $error("stop raised on a load item");

  a_stage_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(s_valid) |-> $past(cmd.valid && cmd.ready))
    else $error("input stage filled without an accepted item");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s_valid && o_valid && !rsp.ready))
    else $error("input stalled while a stage was free");

endmodule

// ----- hdl/drs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// drs_cfg_regs
// Ramp mode and step size registers, written through the config port.
// ----------------------------------------------------------------------------
module drs_cfg_regs
  import drs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output drs_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_mode <= DIR_UP;
      cfg.step_size <= STEP_BITS'(1);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RAMP_MODE: cfg.ramp_mode <= dir_t'(cfg_data[DIR_BITS-1:0]);
        REG_STEP_SIZE: cfg.step_size <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/drs_step_core.sv -----
// ----------------------------------------------------------------------------
// drs_step_core
// Ramp state (code, cycle direction, prepared frame) and the per-item step.
// ----------------------------------------------------------------------------
module drs_step_core
  import drs_pkg::*;
#(
  parameter int CODE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  op_t                  operation,
  input  logic [CODE_BITS-1:0] load_value,
  input  drs_cfg_t             cfg,
  output logic                 frame_sent,
  output logic [HALF_BITS-1:0] sent_high_half,
  output logic [HALF_BITS-1:0] sent_low_half,
  output logic [CODE_BITS-1:0] code_now,
  output logic                 stop_ramp
);

  localparam int SUM_BITS = ((CODE_BITS > STEP_BITS) ? CODE_BITS : STEP_BITS) + 1;
  localparam logic [SUM_BITS-1:0] CODE_MAX = SUM_BITS'({CODE_BITS{1'b1}});

  logic [CODE_BITS-1:0] ramp_code, ramp_code_next;
  logic                 cycle_going_up, cycle_going_up_next;
  logic [HALF_BITS-1:0] prepared_high, prepared_high_next;
  logic [HALF_BITS-1:0] prepared_low, prepared_low_next;

  logic [SUM_BITS-1:0]   code_ext, step_ext, up_sum, down_diff;
  logic                  up_ok, down_ok, stop;
  logic [FRAME_BITS-1:0] frame;

  assign code_ext  = SUM_BITS'(ramp_code);
  assign step_ext  = SUM_BITS'(cfg.step_size);
  assign up_sum    = code_ext + step_ext;
  assign down_diff = code_ext - step_ext;
  assign up_ok     = (up_sum <= CODE_MAX);
  assign down_ok   = (code_ext >= step_ext);

  always_comb begin
    ramp_code_next      = ramp_code;
    cycle_going_up_next = cycle_going_up;
    stop                = 1'b0;
    if (operation == OP_LOAD) begin
      ramp_code_next = load_value;
    end else begin
      case (cfg.ramp_mode)
        DIR_UP: begin
          if (up_ok) ramp_code_next = up_sum[CODE_BITS-1:0];
          else stop = 1'b1;
        end
        DIR_DOWN: begin
          if (down_ok) ramp_code_next = down_diff[CODE_BITS-1:0];
          else stop = 1'b1;
        end
        DIR_CYCLE: begin
          if (cycle_going_up) begin
            if (up_ok) ramp_code_next = up_sum[CODE_BITS-1:0];
            else cycle_going_up_next = 1'b0;
          end else begin
            if (down_ok) ramp_code_next = down_diff[CODE_BITS-1:0];
            else cycle_going_up_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign frame = FRAME_WRITE_CMD + (FRAME_BITS'(ramp_code_next) << FRAME_SHIFT);

  always_comb begin
    prepared_high_next = prepared_high;
    prepared_low_next  = prepared_low;
    if (operation == OP_TICK && !stop) begin
      prepared_high_next = frame[FRAME_BITS-1:HALF_BITS];
      prepared_low_next  = frame[HALF_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_code      <= {1'b1, {(CODE_BITS-1){1'b0}}};
      cycle_going_up <= 1'b0;
      prepared_high  <= '0;
      prepared_low   <= '0;
    end else if (fire) begin
      ramp_code      <= ramp_code_next;
      cycle_going_up <= cycle_going_up_next;
      prepared_high  <= prepared_high_next;
      prepared_low   <= prepared_low_next;
    end
  end

  assign frame_sent     = (operation == OP_TICK);
  assign sent_high_half = frame_sent ? prepared_high : '0;
  assign sent_low_half  = frame_sent ? prepared_low : '0;
  assign code_now       = ramp_code_next;
  assign stop_ramp      = stop;

endmodule

// ----- dv/drs_ramp_checker.sv -----
// ----------------------------------------------------------------------------
// drs_ramp_checker
// Watches the register port and both item channels of the ramp stepper. It
// keeps its own copy of the ramp code, cycle direction and prepared frame.
// For each accepted item it computes the expected result and queues it. Each
// accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module drs_ramp_checker
  import drs_pkg::*;
#(
  parameter int CODE_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  drs_in_if                   cmd,
  drs_out_if                  rsp,
  output int                  pending,
  output int                  errors
);

  typedef struct packed {
    logic                 sent;
    logic [HALF_BITS-1:0] high_half;
    logic [HALF_BITS-1:0] low_half;
    logic [CODE_BITS-1:0] code;
    logic                 stop;
  } ramp_result_t;

  logic [DIR_BITS-1:0]  dir_q;
  logic [STEP_BITS-1:0] step_q;
  logic [CODE_BITS-1:0] code_q;
  logic                 going_up_q;
  logic [HALF_BITS-1:0] prep_high_q;
  logic [HALF_BITS-1:0] prep_low_q;

  ramp_result_t expected_results[$];
  int           mismatches = 0;
  int           waiting = 0;

  assign pending = waiting;
  assign errors  = mismatches;

  task automatic step_ramp(input logic op, input logic [CODE_BITS-1:0] value,
                           output ramp_result_t res);
    logic [CODE_BITS:0]   sum;
    logic [FRAME_BITS-1:0] frame;
    res = '0;
    if (op == OP_LOAD) begin
      code_q = value;
    end else begin
      res.sent      = 1'b1;
      res.high_half = prep_high_q;
      res.low_half  = prep_low_q;
      sum = (CODE_BITS+1)'(code_q) + (CODE_BITS+1)'(step_q);
      case (dir_q)
        DIR_UP: begin
          if (sum[CODE_BITS]) res.stop = 1'b1;
          else code_q = sum[CODE_BITS-1:0];
        end
        DIR_DOWN: begin
          if (code_q >= step_q) code_q = code_q - step_q;
          else res.stop = 1'b1;
        end
        DIR_CYCLE: begin
          if (going_up_q) begin
            if (sum[CODE_BITS]) going_up_q = 1'b0;
            else code_q = sum[CODE_BITS-1:0];
          end else begin
            if (code_q >= step_q) code_q = code_q - step_q;
            else going_up_q = 1'b1;
          end
        end
        default: ;
      endcase
      if (!res.stop) begin
        frame = FRAME_WRITE_CMD + (FRAME_BITS'(code_q) << FRAME_SHIFT);
        prep_high_q = frame[FRAME_BITS-1:HALF_BITS];
        prep_low_q  = frame[HALF_BITS-1:0];
      end
    end
    res.code = code_q;
  endtask

  always @(posedge clk) begin : watch
    ramp_result_t got;
    ramp_result_t want;
    ramp_result_t res;
    if (rst) begin
      dir_q       = DIR_UP;
      step_q      = STEP_BITS'(1);
      code_q      = CODE_BITS'(1) << (CODE_BITS - 1);
      going_up_q  = 1'b0;
      prep_high_q = '0;
      prep_low_q  = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RAMP_MODE) dir_q = cfg_data[DIR_BITS-1:0];
        else step_q = cfg_data[STEP_BITS-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        got.sent      = rsp.frame_sent;
        got.high_half = rsp.sent_high_half;
        got.low_half  = rsp.sent_low_half;
        got.code      = rsp.code_now;
        got.stop      = rsp.stop_ramp;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sent=%0d high=%h low=%h code=%h stop=%0d",
                     got.sent, got.high_half, got.low_half, got.code, got.stop);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected sent=%0d high=%h low=%h code=%h stop=%0d, %s",
                       want.sent, want.high_half, want.low_half, want.code, want.stop,
                       $sformatf("got sent=%0d high=%h low=%h code=%h stop=%0d",
                                 got.sent, got.high_half, got.low_half, got.code,
                                 got.stop));
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        step_ramp(cmd.operation, cmd.load_value, res);
        expected_results.push_back(res);
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ----- dv/tb_dac_ramp_stepper.sv -----
// ----------------------------------------------------------------------------
// tb_dac_ramp_stepper
// Stimulus for the DAC ramp stepper. A directed part covers the code limits,
// stop and turn at each limit, oversized and zero steps, loads and the unused
// direction code. Then random phases run over many sweep settings. The sender
// works in bursts and the receiver stalls on changing patterns, with one long
// hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dac_ramp_stepper
  import drs_pkg::*;
;

  localparam int CODE_BITS       = 20;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_CYCLES     = 200;
  localparam int HOLD_AFTER      = 440;
  localparam int RANDOM_PHASES   = 14;
  localparam int PHASE_ITEMS     = 75;
  localparam int TAIL_CYCLES     = 8;
  localparam logic [DIR_BITS-1:0]  DIR_UNUSED = 2'd3;
  localparam logic [CODE_BITS-1:0] CODE_TOP   = '1;
  localparam logic [STEP_BITS-1:0] STEP_TOP   = '1;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  int pending;
  int errors;
  int results_seen = 0;
  int burst_left = 0;
  int gap_max = 0;

  drs_in_if  #(.CODE_BITS(CODE_BITS)) cmd_ch ();
  drs_out_if #(.CODE_BITS(CODE_BITS)) rsp_ch ();

  dac_ramp_stepper #(.CODE_BITS(CODE_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  drs_ramp_checker #(.CODE_BITS(CODE_BITS)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_item(input op_t op, input logic [CODE_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.load_value <= value;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic drain;
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_sweep(input logic [DIR_BITS-1:0] dir_code,
                           input logic [STEP_BITS-1:0] step);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RAMP_MODE;
    cfg_data  <= CFG_BITS'(dir_code);
    @(posedge clk);
    cfg_index <= REG_STEP_SIZE;
    cfg_data  <= CFG_BITS'(step);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CODE_BITS-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CODE_TOP;
      2: return CODE_TOP - CODE_BITS'($urandom_range(0, 64));
      3: return CODE_BITS'($urandom_range(0, 64));
      default: return CODE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return STEP_BITS'($urandom);
      1: return STEP_BITS'($urandom_range(1, 16));
      2: return STEP_BITS'($urandom_range(1, 4095));
      3: return $urandom_range(0, 1) ? STEP_TOP : '0;
      default: return STEP_BITS'($urandom_range(1, 'h3ffff));
    endcase
  endfunction

  // receiver: changing stall patterns, one long hold-off
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    bit hold_done;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) results_seen++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= (phase % 4 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [DIR_BITS-1:0] dir_code;
    int r;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_RAMP_MODE;
    cfg_data          <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.operation  <= OP_TICK;
    cmd_ch.load_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: sweep up by one
    send_item(OP_TICK, '0);
    send_item(OP_TICK, CODE_TOP);
    send_item(OP_LOAD, CODE_TOP);
    send_item(OP_TICK, '0);
    send_item(OP_LOAD, '0);
    send_item(OP_TICK, '0);
    send_item(OP_LOAD, CODE_TOP - 1'b1);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);

    // full scale step down
    set_sweep(DIR_DOWN, STEP_TOP);
    send_item(OP_LOAD, CODE_TOP);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    send_item(OP_LOAD, CODE_BITS'('h12345));
    send_item(OP_TICK, '0);

    // cycle mode turning at both limits
    set_sweep(DIR_CYCLE, STEP_BITS'('h40000));
    repeat (6) send_item(OP_TICK, '0);

    // unused direction and zero step
    set_sweep(DIR_UNUSED, '0);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    set_sweep(DIR_UP, '0);
    send_item(OP_TICK, '0);
    send_item(OP_LOAD, CODE_BITS'('h55555));
    send_item(OP_TICK, '0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_sweep(DIR_UP, STEP_BITS'(1));
        1: set_sweep(DIR_DOWN, STEP_TOP);
        2: set_sweep(DIR_CYCLE, '0);
        3: set_sweep(DIR_CYCLE, STEP_TOP);
        4: set_sweep(DIR_UNUSED, pick_step());
        default: begin
          r = $urandom_range(0, 9);
          dir_code = (r < 3) ? DIR_UP : (r < 6) ? DIR_DOWN : (r < 9) ? DIR_CYCLE : DIR_UNUSED;
          set_sweep(dir_code, pick_step());
        end
      endcase
      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 12) send_item(OP_LOAD, pick_code());
        else send_item(OP_TICK, CODE_BITS'($urandom));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/drs_pkg.sv
hdl/drs_in_if.sv
hdl/drs_out_if.sv
hdl/drs_cfg_regs.sv
hdl/drs_step_core.sv
hdl/dac_ramp_stepper.sv
dv/drs_ramp_checker.sv
dv/tb_dac_ramp_stepper.sv
